// File: design/wrmv_pkg.sv
package wrmv_pkg;

   localparam int SAMPLE_WIDTH = 32;
   localparam int MAG_WIDTH = SAMPLE_WIDTH + 1;
   localparam int SUM_WIDTH = 48;
   localparam int COUNT_OUT_WIDTH = 32;
   localparam int DIV_WIDTH = SUM_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_WIDTH + 1);
   localparam int MUL_LO_WIDTH = 17;
   localparam int MUL_HI_WIDTH = MAG_WIDTH - MUL_LO_WIDTH;
   localparam int PROD_WIDTH = 2 * MAG_WIDTH;

   localparam int FRACTION_BITS_DEFAULT = 16;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam logic [DIV_CNT_WIDTH-1:0] MEAN_STEPS = DIV_CNT_WIDTH'(MAG_WIDTH);
   localparam logic [DIV_CNT_WIDTH-1:0] VAR_STEPS = DIV_CNT_WIDTH'(DIV_WIDTH);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_DIV_MEAN,
      ST_MEAN_UPD,
      ST_DEV2,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_COMBINE,
      ST_ACCUM,
      ST_DIV_VAR,
      ST_DONE
   } wrmv_state_type;

   typedef struct packed {
      logic accept;
      logic start;
      logic div_step;
      logic mean_update;
      logic dev2;
      logic mul_lo;
      logic mul_hi;
      logic combine;
      logic accum;
      logic result_load;
   } wrmv_cmd_type;

endpackage

// File: design/wrmv_req_if.sv
interface wrmv_req_if import wrmv_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

// File: design/wrmv_rsp_if.sv
interface wrmv_rsp_if import wrmv_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [SAMPLE_WIDTH-1:0]    running_mean;
   logic [SUM_WIDTH-1:0]       variance;
   logic [COUNT_OUT_WIDTH-1:0] count;

   modport source (output valid, output running_mean, output variance, output count,
                   input ready);
   modport sink (input valid, input running_mean, input variance, input count,
                 output ready);
endinterface

// File: design/wrmv_ctrl.sv
module wrmv_ctrl import wrmv_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output wrmv_cmd_type cmd
);

   wrmv_state_type           state_ff, state_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_START;
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            cnt_in    = MEAN_STEPS;
            state_in  = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_WIDTH'(1)) begin
               state_in = ST_MEAN_UPD;
            end
         end
         ST_MEAN_UPD: begin
            cmd.mean_update = 1'b1;
            state_in        = ST_DEV2;
         end
         ST_DEV2: begin
            cmd.dev2 = 1'b1;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_COMBINE;
         end
         ST_COMBINE: begin
            cmd.combine = 1'b1;
            state_in    = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            cnt_in    = VAR_STEPS;
            state_in  = ST_DIV_VAR;
         end
         ST_DIV_VAR: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_WIDTH'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.result_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending transaction");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == ST_START))
      else $error("accepted transaction did not start");

   a_div_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_MEAN || state_ff == ST_DIV_VAR) |-> (cnt_ff != '0))
      else $error("divider step counter ran out");
`endif

endmodule

// File: design/wrmv_dp.sv
module wrmv_dp import wrmv_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   parameter int COUNT_WIDTH   = COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  wrmv_cmd_type               cmd,
   input  logic [SAMPLE_WIDTH-1:0]    req_sample,
   output logic [SAMPLE_WIDTH-1:0]    rsp_running_mean,
   output logic [SUM_WIDTH-1:0]       rsp_variance,
   output logic [COUNT_OUT_WIDTH-1:0] rsp_count
);

   logic [SAMPLE_WIDTH-1:0]           mean_ff;
   logic [SUM_WIDTH-1:0]              sum_ff;
   logic [COUNT_WIDTH-1:0]            count_ff;
   logic [SAMPLE_WIDTH-1:0]           sample_ff;
   logic [MAG_WIDTH-1:0]              mag_d_ff;
   logic                              neg_d_ff;
   logic [MAG_WIDTH-1:0]              mag_d2_ff;
   logic [COUNT_WIDTH-1:0]            div_rem_ff;
   logic [DIV_WIDTH-1:0]              div_quo_ff;
   logic [MAG_WIDTH+MUL_LO_WIDTH-1:0] prod_lo_ff;
   logic [MAG_WIDTH+MUL_HI_WIDTH-1:0] prod_hi_ff;
   logic [PROD_WIDTH-1:0]             prod_ff;
   logic [SAMPLE_WIDTH-1:0]           out_mean_ff;
   logic [SUM_WIDTH-1:0]              out_var_ff;
   logic [COUNT_OUT_WIDTH-1:0]        out_count_ff;

   logic [MAG_WIDTH-1:0]   d, d2, mag_d, mag_d2;
   logic [MAG_WIDTH:0]     mean_ext, q_ext, mean_new;
   logic [COUNT_WIDTH:0]   trial, trial_diff;
   logic                   trial_ge;
   logic [PROD_WIDTH-1:0]  inc_ext;
   logic                   inc_over;
   logic [SUM_WIDTH:0]     sum_add;
   logic [SUM_WIDTH-1:0]   sum_in;

   // deviation from the old mean
   always_comb begin
      d     = {sample_ff[SAMPLE_WIDTH-1], sample_ff} - {mean_ff[SAMPLE_WIDTH-1], mean_ff};
      mag_d = d[MAG_WIDTH-1] ? (~d + 1'b1) : d;
   end

   // deviation from the new mean
   always_comb begin
      d2     = {sample_ff[SAMPLE_WIDTH-1], sample_ff} - {mean_ff[SAMPLE_WIDTH-1], mean_ff};
      mag_d2 = d2[MAG_WIDTH-1] ? (~d2 + 1'b1) : d2;
   end

   always_comb begin
      mean_ext = {{2{mean_ff[SAMPLE_WIDTH-1]}}, mean_ff};
      q_ext    = {1'b0, div_quo_ff[MAG_WIDTH-1:0]};
      mean_new = neg_d_ff ? (mean_ext - q_ext) : (mean_ext + q_ext);
   end

   // restoring divider step, divisor is the running count
   always_comb begin
      trial      = {div_rem_ff, div_quo_ff[DIV_WIDTH-1]};
      trial_ge   = (trial >= {1'b0, count_ff});
      trial_diff = trial - {1'b0, count_ff};
   end

   // saturating accumulate of the scaled deviation product
   always_comb begin
      inc_ext  = prod_ff >> FRACTION_BITS;
      inc_over = |inc_ext[PROD_WIDTH-1:SUM_WIDTH];
      sum_add  = {1'b0, sum_ff} + {1'b0, inc_ext[SUM_WIDTH-1:0]};
      if (inc_over || sum_add[SUM_WIDTH]) begin
         sum_in = '1;
      end else begin
         sum_in = sum_add[SUM_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff  <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.accept && (count_ff != '1)) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.mean_update) begin
            mean_ff <= mean_new[SAMPLE_WIDTH-1:0];
         end
         if (cmd.accum) begin
            sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
      if (cmd.start) begin
         mag_d_ff   <= mag_d;
         neg_d_ff   <= d[MAG_WIDTH-1];
         div_rem_ff <= '0;
         div_quo_ff <= {mag_d, (DIV_WIDTH - MAG_WIDTH)'(0)};
      end else if (cmd.accum) begin
         div_rem_ff <= '0;
         div_quo_ff <= sum_in;
      end else if (cmd.div_step) begin
         div_rem_ff <= trial_ge ? trial_diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
         div_quo_ff <= {div_quo_ff[DIV_WIDTH-2:0], trial_ge};
      end
      if (cmd.dev2) begin
         mag_d2_ff <= mag_d2;
      end
      if (cmd.mul_lo) begin
         prod_lo_ff <= (MAG_WIDTH+MUL_LO_WIDTH)'(mag_d_ff) *
                       (MAG_WIDTH+MUL_LO_WIDTH)'(mag_d2_ff[MUL_LO_WIDTH-1:0]);
      end
      if (cmd.mul_hi) begin
         prod_hi_ff <= (MAG_WIDTH+MUL_HI_WIDTH)'(mag_d_ff) *
                       (MAG_WIDTH+MUL_HI_WIDTH)'(mag_d2_ff[MAG_WIDTH-1:MUL_LO_WIDTH]);
      end
      if (cmd.combine) begin
         prod_ff <= PROD_WIDTH'(prod_lo_ff) + (PROD_WIDTH'(prod_hi_ff) << MUL_LO_WIDTH);
      end
      if (cmd.result_load) begin
         out_mean_ff  <= mean_ff;
         out_var_ff   <= div_quo_ff;
         out_count_ff <= COUNT_OUT_WIDTH'(count_ff);
      end
   end

   assign rsp_running_mean = out_mean_ff;
   assign rsp_variance     = out_var_ff;
   assign rsp_count        = out_count_ff;

`ifndef ASSERT_OFF
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (count_ff >= $past(count_ff)))
      else $error("sample count went backward");

   a_sum_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (sum_ff >= $past(sum_ff)))
      else $error("squared deviation sum went backward");
`endif

endmodule

// File: design/welford_running_mean_variance.sv
// Running mean and variance of a stream of signed fixed-point samples.
// req_chan carries one sample per transaction (valid/ready, taken on a
// clock edge with both high). rsp_chan returns one transaction per sample:
// the updated running mean, the population variance (squared deviation
// sum over count) and the saturating sample count.
// Sequence: a sample is taken only while the block is idle. The controller
// then runs a 33-step division of the deviation by the count, the mean
// update, split multiply and accumulate steps, and a 48-step division of
// the sum by the count, all on one shared radix-2 divider. The result is
// then loaded into the output register and the block returns to idle; a
// new sample is not taken until the last one is through.
// If rsp_chan stalls, the pending result holds in the output register and
// the next sample is still taken and computed; its result waits in the
// datapath until the output register frees.
// Synchronous reset clears the mean, the sum and the count to zero and
// drops any pending result.
module welford_running_mean_variance import wrmv_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   parameter int COUNT_WIDTH   = COUNT_WIDTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   wrmv_req_if.sink   req_chan,
   wrmv_rsp_if.source rsp_chan
);

   wrmv_cmd_type cmd;

   wrmv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   wrmv_dp #(
      .FRACTION_BITS (FRACTION_BITS),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_sample       (req_chan.sample),
      .rsp_running_mean (rsp_chan.running_mean),
      .rsp_variance     (rsp_chan.variance),
      .rsp_count        (rsp_chan.count)
   );

endmodule
